### rtl/mbwr_pkg.sv
package mbwr_pkg;

  // Largest register count that a frame may carry.
  localparam logic [6:0] MAX_REGS = 7'd123;

  // Function code for write multiple registers.
  localparam logic [7:0] FN_WRITE_REGS = 8'h10;

  // Fixed characters of the frame.
  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;

  // Input item kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  // Character counts of the body of each job, without the trailer.
  localparam logic [4:0] HDR_BODY_LEN = 5'd15;
  localparam logic [4:0] VAL_BODY_LEN = 5'd4;

  // Job queue between the front and the back (a power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One unit of work for the character serializer.
  typedef struct packed {
    logic       is_hdr;   // header job, else value job
    logic       trailer;  // append LRC, CR and LF after the body
    logic [7:0] addr;     // slave address (header)
    logic [15:0] word;    // start register (header) or value word
    logic [6:0] count;    // saturated register count (header)
  } job_t;

  // Upper-case hex character of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + ext;
    end else begin
      hex_char = 8'h37 + ext;
    end
  endfunction

endpackage

### rtl/mbwr_queue.sv
module mbwr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbwr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mbwr_pkg::job_t head_job
);

  mbwr_pkg::job_t                  entries [mbwr_pkg::QUEUE_DEPTH];
  logic [mbwr_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [mbwr_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [mbwr_pkg::QUEUE_AW:0]     fill;

  localparam logic [mbwr_pkg::QUEUE_AW:0] DEPTH_CNT = (mbwr_pkg::QUEUE_AW+1)'(mbwr_pkg::QUEUE_DEPTH);

  assign full       = (fill == DEPTH_CNT);
  assign head_valid = (fill != '0);
  assign head_job   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/mbwr_front.sv
module mbwr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           kind,
  input  logic           enable,
  input  logic [7:0]     slave_address,
  input  logic [15:0]    start_register,
  input  logic [6:0]     register_count,
  input  logic [15:0]    value_word,
  output logic           push,
  output mbwr_pkg::job_t push_job,
  input  logic           queue_full
);

  logic [6:0] values_left;
  logic [6:0] values_left_next;
  logic [6:0] sat_count;
  logic       accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  assign sat_count = (register_count > mbwr_pkg::MAX_REGS) ? mbwr_pkg::MAX_REGS
                                                            : register_count;

  // Classify the item and build its job.
  always_comb begin
    push             = 1'b0;
    values_left_next = values_left;
    push_job.is_hdr  = 1'b0;
    push_job.trailer = 1'b0;
    push_job.addr    = slave_address;
    push_job.word    = value_word;
    push_job.count   = sat_count;
    if (accept) begin
      if (kind == mbwr_pkg::KIND_HEADER) begin
        if (enable) begin
          push             = 1'b1;
          push_job.is_hdr  = 1'b1;
          push_job.trailer = (sat_count == 7'd0);
          push_job.word    = start_register;
          values_left_next = sat_count;
        end
      end else if (values_left != 7'd0) begin
        push             = 1'b1;
        push_job.trailer = (values_left == 7'd1);
        values_left_next = values_left - 7'd1;
      end
    end
  end

  // A frame is open while values are still expected.
  always_ff @(posedge clk) begin
    if (rst) begin
      values_left <= '0;
    end else begin
      values_left <= values_left_next;
    end
  end

endmodule

### rtl/mbwr_back.sv
module mbwr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  mbwr_pkg::job_t job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     ascii_char,
  output logic           frame_end
);

  logic [4:0] pos;
  logic [7:0] running_lrc;
  logic [4:0] body_len;
  logic [4:0] last_pos;
  logic [4:0] pos_m1;
  logic [4:0] tpos_full;
  logic [1:0] tpos;
  logic       in_body;
  logic       hi_nib;
  logic       at_last;
  logic       advance;
  logic [7:0] cur_byte;
  logic [7:0] lrc_neg;
  logic [7:0] char_next;
  logic       end_next;

  assign advance = job_valid && (!out_valid || !out_stall);

  // Pick the byte and nibble that the current position emits.
  always_comb begin
    body_len  = job.is_hdr ? mbwr_pkg::HDR_BODY_LEN : mbwr_pkg::VAL_BODY_LEN;
    last_pos  = job.trailer ? (body_len + 5'd3) : (body_len - 5'd1);
    at_last   = (pos == last_pos);
    in_body   = (pos < body_len);
    pos_m1    = pos - 5'd1;
    tpos_full = pos - body_len;
    tpos      = tpos_full[1:0];
    lrc_neg   = 8'd0 - running_lrc;
    if (job.is_hdr) begin
      hi_nib = !pos_m1[0];
      case (pos_m1[3:1])
        3'd0:    cur_byte = job.addr;
        3'd1:    cur_byte = mbwr_pkg::FN_WRITE_REGS;
        3'd2:    cur_byte = job.word[15:8];
        3'd3:    cur_byte = job.word[7:0];
        3'd4:    cur_byte = 8'h00;
        3'd5:    cur_byte = {1'b0, job.count};
        3'd6:    cur_byte = {job.count, 1'b0};
        default: cur_byte = 8'h00;
      endcase
    end else begin
      hi_nib   = !pos[0];
      cur_byte = pos[1] ? job.word[7:0] : job.word[15:8];
    end
  end

  // Character for the current position.
  always_comb begin
    end_next = 1'b0;
    if (job.is_hdr && (pos == 5'd0)) begin
      char_next = mbwr_pkg::COLON_CHAR;
    end else if (in_body) begin
      char_next = mbwr_pkg::hex_char(hi_nib ? cur_byte[7:4] : cur_byte[3:0]);
    end else begin
      case (tpos)
        2'd0:    char_next = mbwr_pkg::hex_char(lrc_neg[7:4]);
        2'd1:    char_next = mbwr_pkg::hex_char(lrc_neg[3:0]);
        2'd2:    char_next = mbwr_pkg::CR_CHAR;
        default: begin
          char_next = mbwr_pkg::LF_CHAR;
          end_next  = 1'b1;
        end
      endcase
    end
  end

  assign pop = advance && at_last;

  // Position counter and running LRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      running_lrc <= '0;
    end else if (advance) begin
      pos <= at_last ? 5'd0 : (pos + 5'd1);
      if (job.is_hdr && (pos == 5'd0)) begin
        running_lrc <= 8'd0;
      end else if (in_body && !hi_nib) begin
        running_lrc <= running_lrc + cur_byte;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ascii_char <= char_next;
      frame_end  <= end_next;
    end
  end

endmodule

### rtl/modbus_ascii_write_regs_framer.sv
// Channel   Handshake            Payload
// input     in_valid, in_stall   kind, enable, slave_address, start_register,
//                                register_count, value_word
// output    out_valid, out_stall ascii_char, frame_end
//
// The front takes one item per cycle while the two-entry job queue has room.
// The back emits one character per cycle while a job waits and no output
// stall holds it: a value item has 4 characters, a header 15, and a frame's
// last value or a zero-count header 4 more for the trailer. The character
// serializer sets the sustained rate. Reset clears the open frame, the queue
// and the output valid flag. Output stalls hold the character register; the
// input stalls only when the queue is full.
module modbus_ascii_write_regs_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic        enable,
  input  logic [7:0]  slave_address,
  input  logic [15:0] start_register,
  input  logic [6:0]  register_count,
  input  logic [15:0] value_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  ascii_char,
  output logic        frame_end
);

  logic           push;
  logic           queue_full;
  logic           pop;
  logic           head_valid;
  mbwr_pkg::job_t push_job;
  mbwr_pkg::job_t head_job;

  // Item classification and frame tracking.
  mbwr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .enable         (enable),
    .slave_address  (slave_address),
    .start_register (start_register),
    .register_count (register_count),
    .value_word     (value_word),
    .push           (push),
    .push_job       (push_job),
    .queue_full     (queue_full)
  );

  // Job queue between the two sides.
  mbwr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Character serializer with LRC.
  mbwr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (head_valid),
    .job        (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char),
    .frame_end  (frame_end)
  );

endmodule

### sim/tb_modbus_ascii_write_regs_framer.sv
`timescale 1ns / 100ps

module tb_modbus_ascii_write_regs_framer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  // One character of the frame as it should leave the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = mbwr_pkg::KIND_HEADER;
  logic        enable = 1'b0;
  logic [7:0]  slave_address = 8'h00;
  logic [15:0] start_register = 16'h0000;
  logic [6:0]  register_count = 7'd0;
  logic [15:0] value_word = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  ascii_char;
  logic        frame_end;

  // Predictor state.
  logic [7:0]  frame_sum = 8'h00;
  logic [6:0]  regs_pending = 7'd0;
  logic        frame_live = 1'b0;
  frame_char_t expected_chars[$];

  // Test control.
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;

  modbus_ascii_write_regs_framer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .enable(enable),
    .slave_address(slave_address),
    .start_register(start_register),
    .register_count(register_count),
    .value_word(value_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ascii_char(ascii_char),
    .frame_end(frame_end)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit in case the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("modbus_ascii_write_regs_framer test failed");
    $finish;
  end

  // Upper-case ASCII hex digit of one nibble.
  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return 8'h41 + {4'h0, nib} - 8'd10;
    end
    return 8'h30 + {4'h0, nib};
  endfunction

  function automatic void queue_char(input logic [7:0] ch, input logic last);
    frame_char_t fc;
    fc.ch = ch;
    fc.last = last;
    expected_chars.push_back(fc);
  endfunction

  // One byte goes out as two hex digits and adds into the checksum.
  function automatic void queue_hex_byte(input logic [7:0] b);
    frame_sum = frame_sum + b;
    queue_char(nibble_ascii(b[7:4]), 1'b0);
    queue_char(nibble_ascii(b[3:0]), 1'b0);
  endfunction

  // Checksum, CR and LF close the frame.
  function automatic void queue_trailer();
    logic [7:0] lrc;
    lrc = 8'h00 - frame_sum;
    queue_char(nibble_ascii(lrc[7:4]), 1'b0);
    queue_char(nibble_ascii(lrc[3:0]), 1'b0);
    queue_char(mbwr_pkg::CR_CHAR, 1'b0);
    queue_char(mbwr_pkg::LF_CHAR, 1'b1);
    frame_live = 1'b0;
    regs_pending = 7'd0;
  endfunction

  // Characters that one accepted item produces, with the frame state update.
  function automatic void predict_frame_chars(input logic k, input logic en,
                                              input logic [7:0] addr,
                                              input logic [15:0] first_reg,
                                              input logic [6:0] cnt,
                                              input logic [15:0] val);
    logic [6:0] sat_cnt;
    if (k == mbwr_pkg::KIND_HEADER) begin
      if (!en) begin
        return;
      end
      sat_cnt = (cnt > mbwr_pkg::MAX_REGS) ? mbwr_pkg::MAX_REGS : cnt;
      frame_sum = 8'h00;
      queue_char(mbwr_pkg::COLON_CHAR, 1'b0);
      queue_hex_byte(addr);
      queue_hex_byte(mbwr_pkg::FN_WRITE_REGS);
      queue_hex_byte(first_reg[15:8]);
      queue_hex_byte(first_reg[7:0]);
      queue_hex_byte(8'h00);
      queue_hex_byte({1'b0, sat_cnt});
      queue_hex_byte({sat_cnt, 1'b0});
      regs_pending = sat_cnt;
      frame_live = 1'b1;
      if (sat_cnt == 7'd0) begin
        queue_trailer();
      end
    end else begin
      if (!frame_live || regs_pending == 7'd0) begin
        return;
      end
      queue_hex_byte(val[15:8]);
      queue_hex_byte(val[7:0]);
      regs_pending = regs_pending - 7'd1;
      if (regs_pending == 7'd0) begin
        queue_trailer();
      end
    end
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Output side: compare every accepted character with the oldest expectation.
  // The sample is taken at the edge and compared a little later, so that an
  // item accepted at the same edge has already been predicted.
  initial begin
    logic        got_fire;
    logic [7:0]  got_ch;
    logic        got_last;
    frame_char_t want;
    forever begin
      @(posedge clk);
      got_fire = (out_valid === 1'b1) && (out_stall == 1'b0) && (rst == 1'b0);
      got_ch = ascii_char;
      got_last = frame_end;
      #1;
      if (got_fire) begin
        if (expected_chars.size() == 0) begin
          log_mismatch($sformatf("unexpected char 0x%02h last %0b at cycle %0d",
                                 got_ch, got_last, cycle_count));
        end else begin
          want = expected_chars.pop_front();
          if (got_ch !== want.ch) begin
            log_mismatch($sformatf("ascii_char: expected 0x%02h, got 0x%02h at cycle %0d",
                                   want.ch, got_ch, cycle_count));
          end
          if (got_last !== want.last) begin
            log_mismatch($sformatf("frame_end: expected %0b, got %0b at cycle %0d",
                                   want.last, got_last, cycle_count));
          end
        end
      end
    end
  end

  // Output stall: random bursts, plus one long hold-off on request.
  initial begin
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(0, 18);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item, with an optional gap ahead of it, and predict it once taken.
  task automatic send_item(input logic k, input logic en, input logic [7:0] addr,
                           input logic [15:0] first_reg, input logic [6:0] cnt,
                           input logic [15:0] val);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    enable <= en;
    slave_address <= addr;
    start_register <= first_reg;
    register_count <= cnt;
    value_word <= val;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    predict_frame_chars(k, en, addr, first_reg, cnt, val);
  endtask

  // Unused fields of each kind carry random values.
  task automatic send_header(input logic en, input logic [7:0] addr,
                             input logic [15:0] first_reg, input logic [6:0] cnt);
    send_item(mbwr_pkg::KIND_HEADER, en, addr, first_reg, cnt, 16'($urandom));
  endtask

  task automatic send_value(input logic [15:0] val);
    send_item(mbwr_pkg::KIND_VALUE, 1'($urandom), 8'($urandom), 16'($urandom),
              7'($urandom), val);
  endtask

  // Stop offering items and wait for every expected character.
  task automatic drain_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_ignored_items();
    send_value(16'hFFFF);
    send_header(1'b0, 8'hFF, 16'hFFFF, 7'h7F);
  endtask

  task automatic test_zero_count();
    send_header(1'b1, 8'h00, 16'h0000, 7'd0);
  endtask

  task automatic test_field_extremes();
    send_header(1'b1, 8'hFF, 16'hFFFF, 7'd1);
    send_value(16'hFFFF);
    send_header(1'b1, 8'h01, 16'h8000, 7'd1);
    send_value(16'h0000);
  endtask

  // A disabled header inside a frame leaves it open; a stray value follows.
  task automatic test_disabled_header_in_frame();
    send_header(1'b1, 8'h5A, 16'h1234, 7'd2);
    send_header(1'b0, 8'($urandom), 16'($urandom), 7'($urandom));
    send_value(16'hA5C3);
    send_header(1'b0, 8'($urandom), 16'($urandom), 7'd0);
    send_value(16'h0F1E);
    send_value(16'h1111);
  endtask

  // A saturated count, then a new header drops the frame mid-way.
  task automatic test_saturated_restart();
    send_header(1'b1, 8'h11, 16'h00FF, 7'd124);
    send_value(16'h7E81);
    send_value(16'h00FF);
    send_header(1'b1, 8'h22, 16'hABCD, 7'd3);
    send_value(16'h1234);
    send_value(16'hFEDC);
    send_value(16'h8001);
  endtask

  // The longest frame the block allows, from a count that saturates.
  task automatic test_full_length_frame();
    send_header(1'b1, 8'($urandom), 16'($urandom), 7'h7F);
    for (int i = 0; i < mbwr_pkg::MAX_REGS; i++) begin
      send_value(16'($urandom));
    end
  endtask

  // The receiver holds off while frames keep coming, so the input backs up.
  task automatic test_long_hold();
    hold_request = 1'b1;
    send_header(1'b1, 8'($urandom), 16'($urandom), 7'd4);
    for (int i = 0; i < 4; i++) begin
      send_value(16'($urandom));
    end
    send_header(1'b1, 8'($urandom), 16'($urandom), 7'd0);
    send_header(1'b1, 8'($urandom), 16'($urandom), 7'd1);
    send_value(16'($urandom));
    drain_frames();
  endtask

  // Mostly whole frames with random content, some cut short, plus noise.
  task automatic test_random_frames(input int item_target);
    int sent;
    int choice;
    int cnt;
    int vals;
    sent = 0;
    while (sent < item_target) begin
      choice = $urandom_range(0, 9);
      if (choice < 8) begin
        if ($urandom_range(0, 5) == 0) begin
          cnt = $urandom_range(0, 127);
        end else begin
          cnt = $urandom_range(0, 6);
        end
        vals = (cnt > mbwr_pkg::MAX_REGS) ? mbwr_pkg::MAX_REGS : cnt;
        if (vals > 8) begin
          vals = $urandom_range(0, 4);
        end else if (choice == 7 && vals > 0) begin
          vals = $urandom_range(0, vals - 1);
        end
        send_header(1'b1, 8'($urandom), 16'($urandom), 7'(cnt));
        sent++;
        for (int i = 0; i < vals; i++) begin
          if ($urandom_range(0, 15) == 0) begin
            send_header(1'b0, 8'($urandom), 16'($urandom), 7'($urandom));
          end
          send_value(16'($urandom));
          sent++;
        end
      end else if (choice == 8) begin
        send_value(16'($urandom));
      end else begin
        send_header(1'b0, 8'($urandom), 16'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ignored_items();
    test_zero_count();
    test_field_extremes();
    test_disabled_header_in_frame();
    test_saturated_restart();
    test_full_length_frame();
    drain_frames();
    test_long_hold();
    test_random_frames(55);
    drain_frames();
    idle_on = 1'b0;
    test_random_frames(20);
    drain_frames();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("modbus_ascii_write_regs_framer test passed");
    end else begin
      $display("modbus_ascii_write_regs_framer test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mbwr_pkg.sv
rtl/mbwr_queue.sv
rtl/mbwr_front.sv
rtl/mbwr_back.sv
rtl/modbus_ascii_write_regs_framer.sv
sim/tb_modbus_ascii_write_regs_framer.sv
